@@ hdl/i6p_pkg.sv @@
// ----------------------------------------------------------------------------
// i6p_pkg - shared types and constants of the IPv6 text address parser
// Item types of both channels, the token passed from front to back, and the
// end-of-text snapshot passed from the parser to the address assembler.
// ----------------------------------------------------------------------------
package i6p_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned NumGroups  = 8;

  // character codes
  localparam logic [7:0] CaseBit = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChDot   = 8'h2E;

  localparam logic [13:0] OctetMax = 14'd255;

  typedef enum logic [2:0] {
    CLS_DEC,
    CLS_HEX,
    CLS_COLON,
    CLS_DOT,
    CLS_OTHER
  } cls_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic        ok;
  } out_item_t;

  // classified character
  typedef struct packed {
    cls_e       cls;
    logic [3:0] nib;
    logic       last;
  } tok_t;

  // parser state after the last character of a text
  typedef struct packed {
    logic [NumGroups-1:0][15:0] grp;
    logic [3:0]                 gw;
    logic                       gap_seen;
    logic [3:0]                 gap_pos;
    logic [15:0]                hex;
    logic                       has_digits;
    logic                       tail_mode;
    logic [23:0]                tail;
    logic [7:0]                 oct;
    logic [1:0]                 dot_cnt;
    logic                       failed;
  } fin_t;

endpackage

@@ hdl/i6p_front.sv @@
// ----------------------------------------------------------------------------
// i6p_front - character classifier
// Sorts each incoming character into decimal digit, hex letter, colon, dot or
// other, and extracts its digit value.
// ----------------------------------------------------------------------------
module i6p_front (
  input  i6p_pkg::in_item_t in_item_i,
  output i6p_pkg::tok_t     tok_o
);

  logic [7:0] lc;
  logic       is_dec;
  logic       is_hex;

  assign lc     = in_item_i.ch | i6p_pkg::CaseBit;
  assign is_dec = (in_item_i.ch >= i6p_pkg::ChZero) && (in_item_i.ch <= i6p_pkg::ChNine);
  assign is_hex = (lc >= i6p_pkg::ChLowA) && (lc <= i6p_pkg::ChLowF);

  always_comb begin
    tok_o.last = in_item_i.last;
    tok_o.nib  = in_item_i.ch[3:0];
    priority if (is_dec) begin
      tok_o.cls = i6p_pkg::CLS_DEC;
    end else if (is_hex) begin
      tok_o.cls = i6p_pkg::CLS_HEX;
      tok_o.nib = 4'(lc - i6p_pkg::ChLowA + 8'd10);
    end else if (in_item_i.ch == i6p_pkg::ChColon) begin
      tok_o.cls = i6p_pkg::CLS_COLON;
    end else if (in_item_i.ch == i6p_pkg::ChDot) begin
      tok_o.cls = i6p_pkg::CLS_DOT;
    end else begin
      tok_o.cls = i6p_pkg::CLS_OTHER;
    end
  end

endmodule

@@ hdl/i6p_queue.sv @@
// ----------------------------------------------------------------------------
// i6p_queue - token queue between classifier and parser
// Small FIFO of classified characters; push and pop may occur together.
// ----------------------------------------------------------------------------
module i6p_queue #(
  parameter int unsigned Depth = i6p_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  i6p_pkg::tok_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output i6p_pkg::tok_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  i6p_pkg::tok_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ hdl/i6p_back.sv @@
// ----------------------------------------------------------------------------
// i6p_back - character-by-character parser
// Tracks hex groups, the gap, and the dotted-quad tail; on the last character
// hands a snapshot of the state to the assembler and returns to reset values.
// ----------------------------------------------------------------------------
module i6p_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  i6p_pkg::tok_t tok_i,
  input  logic          tok_valid_i,
  output logic          pop_o,
  output i6p_pkg::fin_t fin_o,
  output logic          fin_valid_o,
  input  logic          fin_ready_i
);

  logic [i6p_pkg::NumGroups-1:0][15:0] grp_q, grp_d;
  logic [3:0]    gw_q, gw_d;
  logic          gap_q, gap_d;
  logic [3:0]    gpos_q, gpos_d;
  logic [15:0]   hex_q, hex_d;
  logic [2:0]    dcnt_q, dcnt_d;
  logic [13:0]   doct_q, doct_d;
  logic          gnd_q, gnd_d;
  logic          colon_q, colon_d;
  logic          tail_q, tail_d;
  logic [23:0]   tval_q, tval_d;
  logic [1:0]    dot_q, dot_d;
  logic          failed_q, failed_d;
  logic          first_q, first_d;
  logic          fin_v_q, fin_v_d;
  i6p_pkg::fin_t fin_q, fin_d;
  logic [13:0]   doct_mul;
  logic          skip;

  assign pop_o       = tok_valid_i && (!fin_v_q || fin_ready_i);
  assign fin_o       = fin_q;
  assign fin_valid_o = fin_v_q;
  assign doct_mul    = 14'((doct_q << 3) + (doct_q << 1) + 14'(tok_i.nib));
  assign skip        = first_q && (tok_i.cls == i6p_pkg::CLS_COLON);

  always_comb begin
    grp_d    = grp_q;
    gw_d     = gw_q;
    gap_d    = gap_q;
    gpos_d   = gpos_q;
    hex_d    = hex_q;
    dcnt_d   = dcnt_q;
    doct_d   = doct_q;
    gnd_d    = gnd_q;
    colon_d  = colon_q;
    tail_d   = tail_q;
    tval_d   = tval_q;
    dot_d    = dot_q;
    failed_d = failed_q;
    first_d  = first_q;
    fin_d    = fin_q;
    fin_v_d  = fin_v_q && !fin_ready_i;

    if (pop_o) begin
      first_d = 1'b0;
      if (!failed_q && !skip) begin
        if (tail_q) begin
          unique case (tok_i.cls)
            i6p_pkg::CLS_DEC: begin
              doct_d = doct_mul;
              if (doct_mul > i6p_pkg::OctetMax) failed_d = 1'b1;
            end
            i6p_pkg::CLS_DOT: begin
              if (dot_q == 2'd3) begin
                failed_d = 1'b1;
              end else begin
                tval_d = {tval_q[15:0], doct_q[7:0]};
                doct_d = '0;
                dot_d  = dot_q + 2'd1;
              end
            end
            default: failed_d = 1'b1;
          endcase
        end else if (tok_i.cls == i6p_pkg::CLS_COLON) begin
          if (dcnt_q != '0) begin
            // close the group; the eighth group may not end in a colon
            if (gw_q >= 4'd7) begin
              failed_d = 1'b1;
            end else begin
              grp_d[gw_q[2:0]] = hex_q;
              gw_d    = gw_q + 4'd1;
              hex_d   = '0;
              dcnt_d  = '0;
              doct_d  = '0;
              gnd_d   = 1'b0;
              colon_d = 1'b1;
            end
          end else if (!gap_q) begin
            gap_d   = 1'b1;
            gpos_d  = gw_q;
            colon_d = 1'b1;
          end else begin
            failed_d = 1'b1;
          end
        end else if ((tok_i.cls == i6p_pkg::CLS_DOT) && (dcnt_q != '0)) begin
          // enter the dotted-quad tail with the current group as first octet
          if ((gw_q > 4'd6) || !colon_q || gnd_q || (doct_q > i6p_pkg::OctetMax)) begin
            failed_d = 1'b1;
          end else begin
            tail_d = 1'b1;
            tval_d = {16'd0, doct_q[7:0]};
            doct_d = '0;
            dot_d  = 2'd1;
          end
        end else if (dcnt_q >= 3'd4) begin
          failed_d = 1'b1;
        end else begin
          dcnt_d = dcnt_q + 3'd1;
          unique case (tok_i.cls)
            i6p_pkg::CLS_DEC: begin
              hex_d  = {hex_q[11:0], tok_i.nib};
              doct_d = doct_mul;
            end
            i6p_pkg::CLS_HEX: begin
              hex_d = {hex_q[11:0], tok_i.nib};
              gnd_d = 1'b1;
            end
            default: failed_d = 1'b1;
          endcase
        end
      end

      if (tok_i.last) begin
        fin_v_d          = 1'b1;
        fin_d.grp        = grp_d;
        fin_d.gw         = gw_d;
        fin_d.gap_seen   = gap_d;
        fin_d.gap_pos    = gpos_d;
        fin_d.hex        = hex_d;
        fin_d.has_digits = (dcnt_d != '0);
        fin_d.tail_mode  = tail_d;
        fin_d.tail       = tval_d;
        fin_d.oct        = doct_d[7:0];
        fin_d.dot_cnt    = dot_d;
        fin_d.failed     = failed_d;
        // back to reset values for the next text
        gw_d     = '0;
        gap_d    = 1'b0;
        gpos_d   = '0;
        hex_d    = '0;
        dcnt_d   = '0;
        doct_d   = '0;
        gnd_d    = 1'b0;
        colon_d  = 1'b0;
        tail_d   = 1'b0;
        tval_d   = '0;
        dot_d    = '0;
        failed_d = 1'b0;
        first_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q     <= '0;
      gap_q    <= 1'b0;
      gpos_q   <= '0;
      hex_q    <= '0;
      dcnt_q   <= '0;
      doct_q   <= '0;
      gnd_q    <= 1'b0;
      colon_q  <= 1'b0;
      tail_q   <= 1'b0;
      tval_q   <= '0;
      dot_q    <= '0;
      failed_q <= 1'b0;
      first_q  <= 1'b1;
      fin_v_q  <= 1'b0;
    end else begin
      gw_q     <= gw_d;
      gap_q    <= gap_d;
      gpos_q   <= gpos_d;
      hex_q    <= hex_d;
      dcnt_q   <= dcnt_d;
      doct_q   <= doct_d;
      gnd_q    <= gnd_d;
      colon_q  <= colon_d;
      tail_q   <= tail_d;
      tval_q   <= tval_d;
      dot_q    <= dot_d;
      failed_q <= failed_d;
      first_q  <= first_d;
      fin_v_q  <= fin_v_d;
    end
  end

  // group store and snapshot: entries are read only after being written
  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
    fin_q <= fin_d;
  end

endmodule

@@ hdl/i6p_asm.sv @@
// ----------------------------------------------------------------------------
// i6p_asm - address assembler and output register
// Pushes the final group(s), checks the group count against the gap, fills
// the gap with zero groups and registers the result item.
// ----------------------------------------------------------------------------
module i6p_asm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  i6p_pkg::fin_t      fin_i,
  input  logic               fin_valid_i,
  output logic               fin_ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output i6p_pkg::out_item_t out_item_o
);

  localparam int unsigned NG = i6p_pkg::NumGroups;

  logic [NG-1:0][15:0] gf;
  logic [NG-1:0][15:0] g;
  logic [31:0]         tail_word;
  logic [15:0]         w_a, w_b;
  logic [3:0]          n_push;
  logic [3:0]          gw_f;
  logic [3:0]          fill;
  logic [3:0]          gap_end;
  logic [3:0]          src;
  logic                end_ok, push_ok, cnt_ok, ok;
  i6p_pkg::out_item_t  res;
  logic                out_v_q;
  i6p_pkg::out_item_t  out_q;

  assign fin_ready_o = !out_v_q || !out_stall_i;
  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;
  assign tail_word   = {fin_i.tail, fin_i.oct};

  always_comb begin
    if (fin_i.tail_mode) begin
      w_a    = tail_word[31:16];
      w_b    = tail_word[15:0];
      n_push = 4'd2;
      end_ok = (fin_i.dot_cnt == 2'd3);
    end else begin
      w_a    = fin_i.hex;
      w_b    = '0;
      n_push = 4'd1;
      end_ok = fin_i.has_digits || fin_i.gap_seen;
    end
    gw_f    = fin_i.gw + n_push;
    push_ok = (gw_f <= 4'(NG));
    cnt_ok  = fin_i.gap_seen ? (gw_f < 4'(NG)) : (gw_f == 4'(NG));
    ok      = !fin_i.failed && end_ok && push_ok && cnt_ok;
    fill    = 4'(NG) - gw_f;
    gap_end = fin_i.gap_pos + fill;

    for (int i = 0; i < NG; i++) begin
      if (4'(i) < fin_i.gw) begin
        gf[i] = fin_i.grp[i];
      end else if (4'(i) == fin_i.gw) begin
        gf[i] = w_a;
      end else begin
        gf[i] = w_b;
      end
    end

    src = '0;
    for (int i = 0; i < NG; i++) begin
      src = 4'(i) - fill;
      if (4'(i) < fin_i.gap_pos) begin
        g[i] = gf[i];
      end else if (4'(i) < gap_end) begin
        g[i] = '0;
      end else begin
        g[i] = gf[src[2:0]];
      end
    end

    res.addr_high = ok ? {g[0], g[1], g[2], g[3]} : '0;
    res.addr_low  = ok ? {g[4], g[5], g[6], g[7]} : '0;
    res.ok        = ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (fin_ready_o) begin
      out_v_q <= fin_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_ready_o && fin_valid_i) begin
      out_q <= res;
    end
  end

endmodule

@@ hdl/ipv6_text_address_parser.sv @@
// ----------------------------------------------------------------------------
// ipv6_text_address_parser - IPv6 address text to 128-bit binary
// Reads an address text one character per item and returns the binary
// address with an ok flag after the character marked last.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   in      | input     | in_valid_i / in_stall_o  | in_item_i  (ch, last)
//   out     | output    | out_valid_o / out_stall_i| out_item_o (addr, ok)
//
// One character item is taken per cycle, sustained, as long as the queue
// between classifier and parser is not full.
// After the edge that accepts the last character, its token passes through the
// parser's snapshot register and the address assembler's output register.
// in_stall_o is raised only when the token queue is full; it never depends
// combinationally on out_stall_i.
// Reset clears all control state at once; no clearing pass is needed.
//
// Structure: i6p_front classifies each character and writes it into i6p_queue;
// i6p_back pops one token per cycle unless stalled by i6p_asm, and updates
// the parse state; on a last token it hands a snapshot to i6p_asm, which
// fills the gap and holds the result in its output register until taken.
// ----------------------------------------------------------------------------
module ipv6_text_address_parser #(
  parameter int unsigned QueueDepth = i6p_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  i6p_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output i6p_pkg::out_item_t out_item_o
);

  i6p_pkg::tok_t tok_in;
  i6p_pkg::tok_t tok_out;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  i6p_pkg::fin_t fin;
  logic          fin_valid;
  logic          fin_ready;

  // stall the input only on a full queue
  assign in_stall_o = q_full;

  i6p_front u_front (
    .in_item_i (in_item_i),
    .tok_o     (tok_in)
  );

  i6p_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .data_i  (tok_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (tok_out)
  );

  i6p_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (tok_out),
    .tok_valid_i (!q_empty),
    .pop_o       (q_pop),
    .fin_o       (fin),
    .fin_valid_o (fin_valid),
    .fin_ready_i (fin_ready)
  );

  i6p_asm u_asm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fin_i       (fin),
    .fin_valid_i (fin_valid),
    .fin_ready_o (fin_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ hdl/i6p_checker.sv @@
// ----------------------------------------------------------------------------
// i6p_checker - port-level assertions for the IPv6 text address parser
// Watches both channels and tracks texts still owed a result.
// ----------------------------------------------------------------------------
module i6p_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input i6p_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input i6p_pkg::out_item_t out_item_o
);

  logic [7:0] pend_q;
  logic       in_last_acc;
  logic       out_acc;

  assign in_last_acc = in_valid_i && !in_stall_o && in_item_i.last;
  assign out_acc     = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_last_acc && !out_acc) begin
      pend_q <= pend_q + 8'd1;
    end else if (out_acc && !in_last_acc) begin
      pend_q <= pend_q - 8'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("stalled result item changed");

  a_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 8'd0)
    else $error("result item without a completed text");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.ok |-> out_item_o.addr_high == '0 &&
                                      out_item_o.addr_low == '0)
    else $error("failed text carries a nonzero address");

endmodule

bind ipv6_text_address_parser i6p_checker u_i6p_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
